// File: design/csl_pkg.sv
`timescale 1ns / 1ps
package csl_pkg;

  typedef struct packed {
    logic [7:0] character;
    logic       word_end;
  } in_word_t;

  typedef struct packed {
    logic [5:0] token_code;
    logic       last_of_run;
  } out_word_t;

  typedef enum logic [3:0] {
    M_IDLE   = 4'd0,
    M_IDENT  = 4'd1,
    M_NUM    = 4'd2,
    M_NUMDOT = 4'd3,
    M_OP     = 4'd4,
    M_Q1     = 4'd5,
    M_Q2     = 4'd6
  } scan_mode_e;

  localparam int unsigned KwCount = 11;
  localparam logic [5:0] TK_UNKNOWN = 6'd0;
  localparam logic [5:0] TK_IDENT   = 6'd41;
  localparam logic [5:0] TK_INT     = 6'd42;
  localparam logic [5:0] TK_FLOAT   = 6'd43;
  localparam logic [5:0] TK_CHARLIT = 6'd44;

  // Bundle of up to four tokens produced by one input word.
  typedef struct packed {
    logic [2:0]      count;
    logic [3:0][5:0] code;
  } tok_group_t;

  // Lexer state carried from one word to the next.
  typedef struct packed {
    scan_mode_e        mode;
    logic [3:0]        len;
    logic [KwCount-1:0] kw;
    logic [7:0]        pend;
    logic              flt;
  } lex_state_t;

  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] p);
    logic [7:0] c;
    c = 8'd0;
    case (k)
      4'd0: case (p) 4'd0: c = "w"; 4'd1: c = "h"; 4'd2: c = "i"; 4'd3: c = "l";
                     4'd4: c = "e"; default: c = 8'd0; endcase
      4'd1: case (p) 4'd0: c = "f"; 4'd1: c = "o"; 4'd2: c = "r"; default: c = 8'd0; endcase
      4'd2: case (p) 4'd0: c = "c"; 4'd1: c = "o"; 4'd2: c = "n"; 4'd3: c = "t";
                     4'd4: c = "i"; 4'd5: c = "n"; 4'd6: c = "u"; 4'd7: c = "e";
                     default: c = 8'd0; endcase
      4'd3: case (p) 4'd0: c = "b"; 4'd1: c = "r"; 4'd2: c = "e"; 4'd3: c = "a";
                     4'd4: c = "k"; default: c = 8'd0; endcase
      4'd4: case (p) 4'd0: c = "i"; 4'd1: c = "f"; default: c = 8'd0; endcase
      4'd5: case (p) 4'd0: c = "e"; 4'd1: c = "l"; 4'd2: c = "s"; 4'd3: c = "e";
                     default: c = 8'd0; endcase
      4'd6: case (p) 4'd0: c = "f"; 4'd1: c = "l"; 4'd2: c = "o"; 4'd3: c = "a";
                     4'd4: c = "t"; default: c = 8'd0; endcase
      4'd7: case (p) 4'd0: c = "i"; 4'd1: c = "n"; 4'd2: c = "t"; default: c = 8'd0; endcase
      4'd8: case (p) 4'd0: c = "c"; 4'd1: c = "h"; 4'd2: c = "a"; 4'd3: c = "r";
                     default: c = 8'd0; endcase
      4'd9: case (p) 4'd0: c = "v"; 4'd1: c = "o"; 4'd2: c = "i"; 4'd3: c = "d";
                     default: c = 8'd0; endcase
      4'd10: case (p) 4'd0: c = "r"; 4'd1: c = "e"; 4'd2: c = "t"; 4'd3: c = "u";
                      4'd4: c = "r"; 4'd5: c = "n"; default: c = 8'd0; endcase
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] kw_len(input logic [3:0] k);
    logic [3:0] l;
    case (k)
      4'd0, 4'd3, 4'd6: l = 4'd5;
      4'd1, 4'd7: l = 4'd3;
      4'd2: l = 4'd8;
      4'd4: l = 4'd2;
      4'd5, 4'd8, 4'd9: l = 4'd4;
      4'd10: l = 4'd6;
      default: l = 4'd0;
    endcase
    return l;
  endfunction

endpackage

// File: design/csl_front.sv
`timescale 1ns / 1ps
// Scan one character per cycle unless full; emit token-code groups.
module csl_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  csl_pkg::in_word_t   in_word_i,
  output logic                grp_valid_o,
  output csl_pkg::tok_group_t grp_o,
  input  logic                grp_full_i
);
  import csl_pkg::*;

  lex_state_t st_q, st_d;
  tok_group_t grp;
  logic       take;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
  function automatic logic [5:0] single_code(input logic [7:0] p);
    logic [5:0] r;
    case (p)
      "+": r = 6'd12; "-": r = 6'd13; "*": r = 6'd14; "/": r = 6'd15;
      "%": r = 6'd16; "=": r = 6'd17; ">": r = 6'd18; "<": r = 6'd19;
      default: r = TK_UNKNOWN;
    endcase
    return r;
  endfunction
  function automatic logic [5:0] pair_code(input logic [7:0] p, input logic [7:0] c);
    logic [5:0] r;
    r = TK_UNKNOWN;
    if (c == "=") begin
      case (p)
        "+": r = 6'd28; "-": r = 6'd29; "*": r = 6'd30; "/": r = 6'd31;
        "%": r = 6'd32; "=": r = 6'd20; ">": r = 6'd22; "<": r = 6'd21;
        "!": r = 6'd23; default: r = TK_UNKNOWN;
      endcase
    end else if (c == p) begin
      case (p)
        "+": r = 6'd24; "-": r = 6'd25; "&": r = 6'd26; "|": r = 6'd27;
        default: r = TK_UNKNOWN;
      endcase
    end
    return r;
  endfunction

  // Push one code into the group.
  function automatic tok_group_t emit(input tok_group_t g, input logic [5:0] k);
    tok_group_t r;
    r = g;
    if (g.count < 3'd4) begin
      r.code[g.count[1:0]] = k;
      r.count = g.count + 3'd1;
    end
    return r;
  endfunction

  function automatic lex_state_t ident_add(input lex_state_t s, input logic [7:0] c);
    lex_state_t r;
    r = s;
    for (int i = 0; i < KwCount; i++) begin
      if (s.len >= kw_len(4'(i)) || kw_char(4'(i), s.len) != c) r.kw[i] = 1'b0;
    end
    r.len = (s.len < 4'd15) ? s.len + 4'd1 : 4'd15;
    return r;
  endfunction

  function automatic logic [5:0] ident_code(input lex_state_t s);
    logic [5:0] r;
    r = TK_IDENT;
    for (int i = KwCount - 1; i >= 0; i--) begin
      if (s.kw[i] && kw_len(4'(i)) == s.len) r = 6'(i + 1);
    end
    return r;
  endfunction

  // Begin a token with a fresh character from idle.
  task automatic start(inout lex_state_t s, inout tok_group_t g, input logic [7:0] c);
    s.mode = M_IDLE;
    if (is_alpha(c)) begin
      s.mode = M_IDENT;
      s.len  = 4'd0;
      s.kw   = '1;
      s = ident_add(s, c);
    end else if (is_digit(c)) begin
      s.mode = M_NUM;
      s.flt  = 1'b0;
    end else begin
      case (c)
        "(": g = emit(g, 6'd33);
        ")": g = emit(g, 6'd34);
        "{": g = emit(g, 6'd35);
        "}": g = emit(g, 6'd36);
        ";": g = emit(g, 6'd37);
        ",": g = emit(g, 6'd38);
        "[": g = emit(g, 6'd39);
        "]": g = emit(g, 6'd40);
        "+", "-", "*", "/", "%", "=", ">", "<", "!", "&", "|": begin
          s.mode = M_OP;
          s.pend = c;
        end
        "'": s.mode = M_Q1;
        " ": ;
        default: g = emit(g, TK_UNKNOWN);
      endcase
    end
  endtask

  // Feed one character to the scanner, no recursion beyond start.
  task automatic feed(inout lex_state_t s, inout tok_group_t g, input logic [7:0] c);
    logic [5:0] k;
    logic [7:0] p;
    case (s.mode)
      M_IDENT: begin
        if (is_alpha(c) || is_digit(c)) s = ident_add(s, c);
        else begin
          g = emit(g, ident_code(s));
          start(s, g, c);
        end
      end
      M_NUM: begin
        if (is_digit(c)) ;
        else if (c == ".") begin
          s.mode = M_NUMDOT;
          s.flt  = 1'b1;
        end else begin
          g = emit(g, s.flt ? TK_FLOAT : TK_INT);
          s.flt = 1'b0;
          start(s, g, c);
        end
      end
      M_NUMDOT: begin
        if (is_digit(c)) s.mode = M_NUM;
        else begin
          g = emit(g, TK_FLOAT);
          s.flt = 1'b0;
          start(s, g, c);
        end
      end
      M_OP: begin
        k = pair_code(s.pend, c);
        if (k != TK_UNKNOWN) begin
          g = emit(g, k);
          s.mode = M_IDLE;
        end else begin
          g = emit(g, single_code(s.pend));
          start(s, g, c);
        end
      end
      M_Q1: begin
        s.pend = c;
        s.mode = M_Q2;
      end
      M_Q2: begin
        if (c == "'") begin
          g = emit(g, TK_CHARLIT);
          s.mode = M_IDLE;
        end else begin
          g = emit(g, TK_UNKNOWN);
          p = s.pend;
          start(s, g, p);
          // second pass: state is never Q2 after start
          case (s.mode)
            M_IDENT: begin
              if (is_alpha(c) || is_digit(c)) s = ident_add(s, c);
              else begin
                g = emit(g, ident_code(s));
                start(s, g, c);
              end
            end
            M_NUM: begin
              if (is_digit(c)) ;
              else if (c == ".") begin
                s.mode = M_NUMDOT;
                s.flt  = 1'b1;
              end else begin
                g = emit(g, s.flt ? TK_FLOAT : TK_INT);
                s.flt = 1'b0;
                start(s, g, c);
              end
            end
            M_OP: begin
              k = pair_code(s.pend, c);
              if (k != TK_UNKNOWN) begin
                g = emit(g, k);
                s.mode = M_IDLE;
              end else begin
                g = emit(g, single_code(s.pend));
                start(s, g, c);
              end
            end
            M_Q1: begin
              s.pend = c;
              s.mode = M_Q2;
            end
            default: start(s, g, c);
          endcase
        end
      end
      default: start(s, g, c);
    endcase
  endtask

  // Close whatever token is open at the end of a word.
  task automatic flush_one(inout lex_state_t s, inout tok_group_t g);
    logic [7:0] p;
    case (s.mode)
      M_IDENT: begin g = emit(g, ident_code(s)); s.mode = M_IDLE; end
      M_NUM: begin
        g = emit(g, s.flt ? TK_FLOAT : TK_INT);
        s.flt = 1'b0;
        s.mode = M_IDLE;
      end
      M_NUMDOT: begin g = emit(g, TK_FLOAT); s.flt = 1'b0; s.mode = M_IDLE; end
      M_OP: begin g = emit(g, single_code(s.pend)); s.mode = M_IDLE; end
      M_Q1: begin g = emit(g, TK_UNKNOWN); s.mode = M_IDLE; end
      M_Q2: begin
        g = emit(g, TK_UNKNOWN);
        p = s.pend;
        start(s, g, p);
      end
      default: s.mode = M_IDLE;
    endcase
  endtask

  // Compute next state and the token group for the incoming character.
  always_comb begin
    lex_state_t s;
    tok_group_t g;
    s = st_q;
    g = '0;
    feed(s, g, in_word_i.character);
    if (in_word_i.word_end) begin
      flush_one(s, g);
      flush_one(s, g);
    end
    st_d = s;
    grp  = g;
  end

  assign full_o      = grp_full_i;
  assign take        = push_i && !grp_full_i;
  assign grp_valid_o = take && (grp.count != 3'd0);
  assign grp_o       = grp;

  // Advance scanner state on each accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{mode: M_IDLE, len: 4'd0, kw: '0, pend: 8'd0, flt: 1'b0};
    end else if (take) begin
      st_q <= st_d;
    end
  end

endmodule

// File: design/csl_back.sv
`timescale 1ns / 1ps
// Hold token groups in a short queue and hand out one token per pop.
module csl_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 grp_valid_i,
  input  csl_pkg::tok_group_t  grp_i,
  output logic                 grp_full_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output csl_pkg::out_word_t   out_word_o
);
  import csl_pkg::*;

  localparam int unsigned Depth = 2;

  tok_group_t  mem_q [Depth];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic [1:0]  pos_q;
  tok_group_t  head;
  logic        do_push, do_pop, grp_done;

  assign head       = mem_q[rd_q];
  assign empty_o    = (cnt_q == 2'd0);
  assign grp_full_o = (cnt_q == 2'(Depth));
  assign do_push    = grp_valid_i;
  assign do_pop     = pop_i && !empty_o;
  assign grp_done   = do_pop && (3'({1'b0, pos_q}) + 3'd1 == head.count);

  assign out_word_o.token_code  = head.code[pos_q];
  assign out_word_o.last_of_run = (3'({1'b0, pos_q}) + 3'd1 == head.count);

  // Store incoming groups.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= grp_i;
  end

  // Advance pointers and the position inside the head group.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
      pos_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (grp_done) begin
        rd_q  <= !rd_q;
        pos_q <= 2'd0;
      end else if (do_pop) begin
        pos_q <= pos_q + 2'd1;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(grp_done);
    end
  end

endmodule

// File: design/c_subset_lexer.sv
`timescale 1ns / 1ps
// Streaming lexer for a small C subset. One character is taken per cycle
// while full is low (push/full); the tokens it completes, up to four,
// appear one per cycle on the result queue while pop is held (empty/pop),
// the last one flagged by last_of_run. The scanner decides a character's
// whole token group combinationally and drops it into a two-entry group
// queue, so input runs at one character per cycle while tokens are
// drained at least as fast as made; a character's N tokens take N pops.
module c_subset_lexer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  csl_pkg::in_word_t  in_word_i,
  output logic               empty,
  input  logic               pop,
  output csl_pkg::out_word_t out_word_o
);
  import csl_pkg::*;

  logic       grp_valid, grp_full;
  tok_group_t grp;

  csl_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .in_word_i,
    .grp_valid_o(grp_valid), .grp_o(grp), .grp_full_i(grp_full)
  );

  csl_back u_back (
    .clk_i, .rst_ni, .grp_valid_i(grp_valid), .grp_i(grp),
    .grp_full_o(grp_full), .empty_o(empty), .pop_i(pop), .out_word_o
  );

endmodule

// File: design/csl_checker.sv
`timescale 1ns / 1ps
module csl_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input csl_pkg::out_word_t out_word_o
);
  import csl_pkg::*;

  // Codes stay in the defined range.
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> out_word_o.token_code <= TK_CHARLIT) else $error("code range");
  // A held result does not change.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(out_word_o)) else $error("result moved");
  // Nothing is waiting after reset.
  a_rst: assert property (@(posedge clk_i)
    !rst_ni |=> empty) else $error("not empty after reset");
  // Input stalls only while results are waiting.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !empty) else $error("full with nothing waiting");

endmodule

bind c_subset_lexer csl_checker u_csl_checker (
  .clk_i, .rst_ni, .full, .empty, .pop, .out_word_o
);
